@@ hw/rtl/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// Range max segment tree - shared package
// Field widths, default sizes, opcodes, engine states and the structs that
// pass between the top level and the tree engine.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int LEAF_COUNT_DEF = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int LEAF_IDX_BITS  = 10;
	localparam int RANGE_END_BITS = 11;
	localparam int DATA_BITS      = 32;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_QRY,
		ST_RESULT
	} eng_state_t;

	typedef struct packed {
		op_t                       opcode;
		logic [LEAF_IDX_BITS-1:0]  leaf_index;
		logic [RANGE_END_BITS-1:0] range_end;
		logic [DATA_BITS-1:0]      value;
	} req_t;

	typedef struct packed {
		logic start;
		logic res_ready;
	} eng_ctl_t;

	typedef struct packed {
		logic                 ready;
		logic                 res_valid;
		logic [DATA_BITS-1:0] res_data;
	} eng_sts_t;

endpackage

@@ hw/rtl/rmst_req_if.sv @@
// ----------------------------------------------------------------------------
// Range max segment tree - request channel
// Valid/ready channel that carries one update or query word.
// ----------------------------------------------------------------------------
interface rmst_req_if import rmst_pkg::*;;
	logic                       valid;
	logic                       ready;
	op_t                        opcode;
	logic [LEAF_IDX_BITS-1:0]   leaf_index;
	logic [RANGE_END_BITS-1:0]  range_end;
	logic [DATA_BITS-1:0]       value;

	modport source (output valid, output opcode, output leaf_index, output range_end,
		output value, input ready);
	modport sink (input valid, input opcode, input leaf_index, input range_end,
		input value, output ready);
endinterface

@@ hw/rtl/rmst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Range max segment tree - response channel
// Valid/ready channel that carries one query answer word.
// ----------------------------------------------------------------------------
interface rmst_rsp_if import rmst_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] range_max;

	modport source (output valid, output range_max, input ready);
	modport sink (input valid, input range_max, output ready);
endinterface

@@ hw/rtl/rmst_engine.sv @@
// ----------------------------------------------------------------------------
// Range max segment tree - tree engine
// Node memory (one write port, two registered read ports) and the sequencer
// that clears it, walks updates toward the root and walks queries upward.
// ----------------------------------------------------------------------------
module rmst_engine import rmst_pkg::*; #(
	parameter int LEAF_COUNT = LEAF_COUNT_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  eng_ctl_t ctl,
	input  req_t     cmd,
	output eng_sts_t sts
);

	localparam int NODE_COUNT = 2 * LEAF_COUNT;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int PTR_BITS   = NODE_BITS + 1;
	localparam int CMP_BITS   = ((NODE_BITS > RANGE_END_BITS) ? NODE_BITS : RANGE_END_BITS) + 1;
	localparam logic [CMP_BITS-1:0]  LEAF_CMP  = CMP_BITS'(LEAF_COUNT);
	localparam logic [NODE_BITS-1:0] NODE_LAST = NODE_BITS'(NODE_COUNT - 1);
	localparam logic [NODE_BITS-1:0] NODE_ROOT = NODE_BITS'(1);

	eng_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mem [NODE_COUNT];
	logic [VALUE_BITS-1:0] rd_a_q, rd_b_q;

	logic                  wr_en;
	logic [NODE_BITS-1:0]  wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic                  rd_a_en, rd_b_en;
	logic [NODE_BITS-1:0]  rd_a_addr, rd_b_addr;

	logic [NODE_BITS-1:0]  clr_q;
	logic [NODE_BITS-1:0]  node_q;
	logic [VALUE_BITS-1:0] cur_q;
	logic [PTR_BITS-1:0]   lo_q, hi_q;
	logic [VALUE_BITS-1:0] left_q, right_q;
	logic                  va_s1, vb_s1;

	// request decode
	logic [CMP_BITS-1:0]   leaf_w, end_w, beg_sat, end_sat;
	logic                  leaf_ok, q_empty, is_query;
	logic [NODE_BITS-1:0]  leaf_node;
	logic [63:0]           value_wide;
	logic [VALUE_BITS-1:0] value_st;

	logic [NODE_BITS-1:0]  parent;
	logic [VALUE_BITS-1:0] upd_max;
	logic                  q_run;
	logic [PTR_BITS-1:0]   hi_m1;
	logic [VALUE_BITS-1:0] res_max;
	logic [63:0]           res_wide;

	assign is_query   = (cmd.opcode == OP_QUERY);
	assign leaf_w     = CMP_BITS'(cmd.leaf_index);
	assign end_w      = CMP_BITS'(cmd.range_end);
	assign beg_sat    = (leaf_w > LEAF_CMP) ? LEAF_CMP : leaf_w;
	assign end_sat    = (end_w > LEAF_CMP) ? LEAF_CMP : end_w;
	assign q_empty    = (beg_sat >= end_sat);
	assign leaf_ok    = (leaf_w < LEAF_CMP);
	assign leaf_node  = NODE_BITS'(leaf_w + LEAF_CMP);
	assign value_wide = 64'(cmd.value);
	assign value_st   = value_wide[VALUE_BITS-1:0];

	assign parent  = node_q >> 1;
	assign upd_max = (cur_q > rd_a_q) ? cur_q : rd_a_q;
	assign q_run   = (lo_q < hi_q);
	assign hi_m1   = hi_q - PTR_BITS'(1);
	assign res_max = (left_q > right_q) ? left_q : right_q;
	assign res_wide = 64'(res_max);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == NODE_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (ctl.start) begin
					if (is_query)
						state_d = q_empty ? ST_RESULT : ST_QRY;
					else if (leaf_ok)
						state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (parent == NODE_ROOT)
					state_d = ST_IDLE;
			end
			ST_QRY: begin
				if (!q_run)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (ctl.res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port control and status
	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = clr_q;
		wr_data       = '0;
		rd_a_en       = 1'b0;
		rd_a_addr     = lo_q[NODE_BITS-1:0];
		rd_b_en       = 1'b0;
		rd_b_addr     = hi_m1[NODE_BITS-1:0];
		sts.ready     = 1'b0;
		sts.res_valid = 1'b0;
		sts.res_data  = res_wide[DATA_BITS-1:0];
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				sts.ready = 1'b1;
				// write the leaf and fetch its sibling in the same cycle
				if (ctl.start && !is_query && leaf_ok) begin
					wr_en     = 1'b1;
					wr_addr   = leaf_node;
					wr_data   = value_st;
					rd_a_en   = 1'b1;
					rd_a_addr = leaf_node ^ NODE_ROOT;
				end
			end
			ST_UPD: begin
				// the sibling is never on the write path, so no forwarding is needed
				wr_en     = 1'b1;
				wr_addr   = parent;
				wr_data   = upd_max;
				rd_a_en   = (parent != NODE_ROOT);
				rd_a_addr = parent ^ NODE_ROOT;
			end
			ST_QRY: begin
				rd_a_en = q_run && lo_q[0];
				rd_b_en = q_run && hi_q[0];
			end
			ST_RESULT: begin
				sts.res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_a_en)
			rd_a_q <= mem[rd_a_addr];
		if (rd_b_en)
			rd_b_q <= mem[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			va_s1   <= 1'b0;
			vb_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + NODE_BITS'(1);
			va_s1 <= rd_a_en && (state_q == ST_QRY);
			vb_s1 <= rd_b_en && (state_q == ST_QRY);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				node_q  <= leaf_node;
				cur_q   <= value_st;
				lo_q    <= PTR_BITS'(beg_sat + LEAF_CMP);
				hi_q    <= PTR_BITS'(end_sat + LEAF_CMP);
				left_q  <= '0;
				right_q <= '0;
			end
			ST_UPD: begin
				node_q <= parent;
				cur_q  <= upd_max;
			end
			ST_QRY: begin
				if (q_run) begin
					lo_q <= (lo_q + PTR_BITS'(lo_q[0])) >> 1;
					hi_q <= hi_q >> 1;
				end
				// fold in what the previous level fetched
				if (va_s1 && rd_a_q > left_q)
					left_q <= rd_a_q;
				if (vb_s1 && rd_b_q > right_q)
					right_q <= rd_b_q;
			end
			default: ;
		endcase
	end

	a_upd_not_node0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> (parent != '0))
		else $error("update walk passed the root");

	a_qry_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QRY) |-> !wr_en)
		else $error("node memory written during a query");

	a_qry_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QRY) |-> (hi_q <= PTR_BITS'(NODE_COUNT)))
		else $error("query pointer beyond the node store");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.res_valid && !ctl.res_ready) |=> (sts.res_valid && $stable(sts.res_data)))
		else $error("query answer dropped or changed while stalled");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q != NODE_LAST) |=> (state_q == ST_CLEAR))
		else $error("clearing pass cut short");

endmodule

@@ hw/rtl/range_max_segment_tree_unit.sv @@
// ----------------------------------------------------------------------------
// Range max segment tree - top level
// Bottom-up segment tree of running maxima with update and range max query.
// ----------------------------------------------------------------------------
// After reset the unit clears its 2*LEAF_COUNT node memory, one node per cycle,
// and takes no request until that pass is done. An update (opcode 0) writes a
// leaf and recomputes each ancestor, one tree level per cycle through the
// single write port, and it returns no word. A query (opcode 1) climbs from
// both range ends, reading up to two nodes per level on the two read ports,
// and returns one word; an empty range answers 0. One request is in flight
// at a time. An output register holds the answer, so the next request is
// taken while it waits.
module range_max_segment_tree_unit import rmst_pkg::*; #(
	parameter int LEAF_COUNT = LEAF_COUNT_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rmst_req_if.sink          req,
	rmst_rsp_if.source        rsp
);

	eng_ctl_t             ctl;
	eng_sts_t             sts;
	req_t                 cmd;
	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_data_q;
	logic                 rsp_free;

	assign cmd.opcode     = req.opcode;
	assign cmd.leaf_index = req.leaf_index;
	assign cmd.range_end  = req.range_end;
	assign cmd.value      = req.value;

	assign req.ready     = sts.ready;
	assign ctl.start     = req.valid && sts.ready;
	assign rsp_free      = !out_valid_q || rsp.ready;
	assign ctl.res_ready = rsp_free;

	assign rsp.valid     = out_valid_q;
	assign rsp.range_max = out_data_q;

	rmst_engine #(
		.LEAF_COUNT (LEAF_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.res_valid && rsp_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sts.res_valid && rsp_free)
			out_data_q <= sts.res_data;
	end

endmodule
